FILE: design/rns_pkg.sv
// shared types and constants for the radius neighbor search block
package rns_pkg;

   // table size and the part of it that can be addressed and searched
   localparam int MAX_AGENTS   = 32;
   localparam int SEARCH_SLOTS = (MAX_AGENTS < 32) ? MAX_AGENTS : 32;
   localparam int IDX_W        = (SEARCH_SLOTS > 1) ? $clog2(SEARCH_SLOTS) : 1;

   // field widths
   localparam int SLOT_W   = 5;
   localparam int COORD_W  = 24;
   localparam int RADIUS_W = 23;
   localparam int MASK_W   = 32;
   localparam int COUNT_W  = 5;

   // arithmetic widths: difference, square, sum of squares, squared radius
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int SQ_W   = 2 * COORD_W + 1;
   localparam int SUM_W  = SQ_W + 1;
   localparam int R2_W   = 2 * RADIUS_W;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(2560);

   // transaction kinds
   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic             store;
      logic             load_query;
      logic             latch_query;
      logic             issue;
      logic [IDX_W-1:0] idx;
   } dp_cmd_type;

endpackage

FILE: design/rns_controller.sv
// sequencer for store and query transactions
module rns_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_kind,
   output logic               busy,
   output logic               rsp_valid,
   output rns_pkg::dp_cmd_type cmd
);
   import rns_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FETCH  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DRAIN0 = 3'd3;
   localparam logic [2:0] S_DRAIN1 = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             accept;
   logic             last_scan;

   assign accept    = start && (state_ff == S_IDLE);
   assign last_scan = (scan_ff == IDX_W'(SEARCH_SLOTS - 1));
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   // commands to the datapath
   always_comb begin
      cmd.store       = accept && (req_kind == KIND_STORE);
      cmd.load_query  = accept && (req_kind == KIND_QUERY);
      cmd.latch_query = (state_ff == S_FETCH);
      cmd.issue       = (state_ff == S_SCAN);
      cmd.idx         = scan_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      case (state_ff)
         S_IDLE: begin
            scan_in = '0;
            if (accept && (req_kind == KIND_QUERY)) state_in = S_FETCH;
         end
         S_FETCH:  state_in = S_SCAN;
         S_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (last_scan) state_in = S_DRAIN0;
         end
         S_DRAIN0: state_in = S_DRAIN1;
         S_DRAIN1: state_in = S_DONE;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

endmodule

FILE: design/rns_datapath.sv
// position table, squared distance pipeline and result registers
module rns_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rns_pkg::dp_cmd_type                 cmd,
   input  logic [rns_pkg::SLOT_W-1:0]          req_slot,
   input  logic signed [rns_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [rns_pkg::COORD_W-1:0]  req_pos_y,
   input  logic                                csr_write_en,
   input  logic [rns_pkg::RADIUS_W-1:0]        csr_write_data,
   output logic [rns_pkg::SLOT_W-1:0]          rsp_query_slot,
   output logic [rns_pkg::MASK_W-1:0]          rsp_neighbor_mask,
   output logic [rns_pkg::COUNT_W-1:0]         rsp_neighbor_count
);
   import rns_pkg::*;

   // position memory and valid bits
   logic [COORD_W-1:0]      mem_x [SEARCH_SLOTS];
   logic [COORD_W-1:0]      mem_y [SEARCH_SLOTS];
   logic [SEARCH_SLOTS-1:0] valid_ff;

   logic [RADIUS_W-1:0] radius_ff;
   logic [R2_W-1:0]     r2_ff;

   logic               in_range;
   logic [IDX_W-1:0]   req_idx;
   logic [IDX_W-1:0]   rd_addr;
   logic [COORD_W-1:0] rd_x_ff, rd_y_ff;

   logic [SLOT_W-1:0]  qslot_ff;
   logic               qok_ff;
   logic [COORD_W-1:0] qx_ff, qy_ff;

   logic               s1_en_ff, s2_en_ff;
   logic [IDX_W-1:0]   s1_idx_ff, s2_idx_ff;

   logic signed [DIFF_W-1:0] dx, dy;
   logic signed [PROD_W-1:0] dx_sq, dy_sq;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic [SUM_W-1:0]         dist2;
   logic                     hit;

   logic [MASK_W-1:0]  mask_ff;
   logic [COUNT_W-1:0] count_ff;

   assign in_range = ({1'b0, req_slot} < (SLOT_W + 1)'(SEARCH_SLOTS));
   assign req_idx  = req_slot[IDX_W-1:0];
   assign rd_addr  = cmd.load_query ? req_idx : cmd.idx;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) radius_ff <= RADIUS_RESET;
      else if (csr_write_en) radius_ff <= csr_write_data;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (cmd.store && in_range) valid_ff[req_idx] <= 1'b1;
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.store && in_range) begin
         mem_x[req_idx] <= req_pos_x;
         mem_y[req_idx] <= req_pos_y;
      end
      if (cmd.load_query || cmd.issue) begin
         rd_x_ff <= mem_x[rd_addr];
         rd_y_ff <= mem_y[rd_addr];
      end
   end

   // query setup: slot, squared radius, queried position
   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         qslot_ff <= req_slot;
         r2_ff    <= R2_W'(radius_ff) * R2_W'(radius_ff);
      end
      if (cmd.latch_query) begin
         qx_ff <= rd_x_ff;
         qy_ff <= rd_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) qok_ff <= 1'b0;
      else if (cmd.load_query) qok_ff <= in_range && valid_ff[req_idx];
   end

   // stage tags: which compares count
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_en_ff <= 1'b0;
         s2_en_ff <= 1'b0;
      end else begin
         s1_en_ff <= cmd.issue && qok_ff && valid_ff[cmd.idx] &&
                     (SLOT_W'(cmd.idx) != qslot_ff);
         s2_en_ff <= s1_en_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= cmd.idx;
      s2_idx_ff <= s1_idx_ff;
   end

   // squares of the coordinate differences
   assign dx    = $signed({rd_x_ff[COORD_W-1], rd_x_ff}) - $signed({qx_ff[COORD_W-1], qx_ff});
   assign dy    = $signed({rd_y_ff[COORD_W-1], rd_y_ff}) - $signed({qy_ff[COORD_W-1], qy_ff});
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;

   always_ff @(posedge clock) begin
      sqx_ff <= dx_sq[SQ_W-1:0];
      sqy_ff <= dy_sq[SQ_W-1:0];
   end

   // sum, compare and accumulate
   assign dist2 = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign hit   = s2_en_ff && (dist2 <= SUM_W'(r2_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.load_query) begin
         mask_ff  <= '0;
         count_ff <= '0;
      end else if (hit) begin
         mask_ff  <= mask_ff | (MASK_W'(1) << s2_idx_ff);
         count_ff <= count_ff + 1'b1;
      end
   end

   assign rsp_query_slot     = qslot_ff;
   assign rsp_neighbor_mask  = mask_ff;
   assign rsp_neighbor_count = count_ff;

endmodule

FILE: design/radius_neighbor_search.sv
// top level of the fixed radius neighbor search block
// store transaction: written at the accepting edge, busy stays low, one per cycle while idle
// query transaction: busy from the accepting edge until the block returns to idle; result
//   strobe in the done state, for one cycle
// query length is set by the position memory read port: one slot per cycle over 32
//   slots, plus a fetch of the queried slot and the pipeline drain states
// synchronous active high reset clears valid bits and control, radius returns to 10.0
module radius_neighbor_search (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [rns_pkg::SLOT_W-1:0]          req_slot,
   input  logic signed [rns_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [rns_pkg::COORD_W-1:0]  req_pos_y,
   output logic                                rsp_valid,
   output logic [rns_pkg::SLOT_W-1:0]          rsp_query_slot,
   output logic [rns_pkg::MASK_W-1:0]          rsp_neighbor_mask,
   output logic [rns_pkg::COUNT_W-1:0]         rsp_neighbor_count,
   input  logic                                csr_write_en,
   input  logic [rns_pkg::RADIUS_W-1:0]        csr_write_data
);
   import rns_pkg::*;

   dp_cmd_type cmd;

   // sequencer
   rns_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_kind),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // table and distance pipeline
   rns_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_slot           (req_slot),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .rsp_query_slot     (rsp_query_slot),
      .rsp_neighbor_mask  (rsp_neighbor_mask),
      .rsp_neighbor_count (rsp_neighbor_count)
   );

endmodule

FILE: design/rns_checker.sv
// port level checks for the radius neighbor search block
module rns_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                req_kind,
   input logic                                rsp_valid,
   input logic [rns_pkg::SLOT_W-1:0]          rsp_query_slot,
   input logic [rns_pkg::MASK_W-1:0]          rsp_neighbor_mask,
   input logic [rns_pkg::COUNT_W-1:0]         rsp_neighbor_count
);
   import rns_pkg::*;

   // block comes out of reset idle
   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("busy or result after reset");

   // a store transaction never holds the block
   a_store_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == KIND_STORE) |=> !busy)
      else $error("store transaction left block busy");

   // a result only appears during a query and lasts one cycle
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 !rsp_valid)
      else $error("result strobe not a single busy cycle");

   // count matches mask
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones(rsp_neighbor_mask) == 32'(rsp_neighbor_count)))
      else $error("neighbor count differs from mask");

   // queried slot is never its own neighbor
   a_no_self: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_neighbor_mask[rsp_query_slot])
      else $error("queried slot set in its own mask");

endmodule

bind radius_neighbor_search rns_checker u_rns_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_kind           (req_kind),
   .rsp_valid          (rsp_valid),
   .rsp_query_slot     (rsp_query_slot),
   .rsp_neighbor_mask  (rsp_neighbor_mask),
   .rsp_neighbor_count (rsp_neighbor_count)
);
